// ===== rtl/rpd_pkg.sv =====
// Shared constants, types and helpers of the run-length pattern decoder.
`default_nettype none

package rpd_pkg;

  localparam int MAX_GRID = 1024;
  localparam int POS_W    = $clog2(MAX_GRID);
  localparam int SIZE_W   = POS_W + 1;
  localparam int CFG_W    = 11;
  localparam int CHAR_W   = 8;
  localparam int RUN_W    = 16;
  localparam int DVD_W    = RUN_W + 1;
  localparam int CNT_W    = $clog2(DVD_W);
  localparam int OFS_W    = ((POS_W > CFG_W) ? POS_W : CFG_W) + 2;
  localparam int PROD_W   = RUN_W + 4;
  localparam int CFG_IDX_W = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_FLD_W   = 2 * POS_W + SIZE_W;
  localparam int OUT_TDATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  localparam logic [RUN_W-1:0]  RUN_MAX     = '1;
  localparam logic [CFG_W-1:0]  GRID_RESET  = CFG_W'(64);

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_B      = 8'h62;
  localparam logic [CHAR_W-1:0] CH_O      = 8'h6F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_W   = 2'd0,
    CFG_GRID_H   = 2'd1,
    CFG_ANCHOR_X = 2'd2,
    CFG_ANCHOR_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    TOK_SKIP,
    TOK_DIGIT,
    TOK_FIN,
    TOK_COL,
    TOK_SPAN,
    TOK_ROW,
    TOK_OTHER
  } tok_e;

  typedef enum logic [1:0] {
    MOP_X,
    MOP_Y,
    MOP_COL,
    MOP_ROW
  } mop_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_C_GO,
    ST_C_WAIT,
    ST_R_GO,
    ST_R_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic mod_start;
    mop_e mop;
    logic emit;
  } rpd_cmd_t;

  typedef struct packed {
    tok_e tok;
    tok_e tok_q;
    logic mod_done;
    logic out_free;
  } rpd_status_t;

  // zero counts as one, oversize clamps to the largest grid
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (int'(v) > MAX_GRID) begin
      r = SIZE_W'(MAX_GRID);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rpd_mod.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle, with sign fix-up.
`default_nettype none

module rpd_mod (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [rpd_pkg::DVD_W-1:0]  dvd_i,
  input  wire logic [rpd_pkg::SIZE_W-1:0] div_i,
  input  wire logic                      neg_i,
  output logic                           done_o,
  output logic [rpd_pkg::POS_W-1:0]      rem_o
);
  import rpd_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [SIZE_W-1:0] div_q, div_d;
  logic              neg_q, neg_d;
  logic [POS_W-1:0]  rem_q, rem_d;
  logic [SIZE_W-1:0] trial;
  logic [SIZE_W-1:0] diff;

  always_comb begin
    trial  = {rem_q, dvd_q[DVD_W-1]};
    diff   = trial - div_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    neg_d  = neg_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dvd_i;
      div_d  = div_i;
      neg_d  = neg_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= div_q) ? diff[POS_W-1:0] : trial[POS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    neg_q <= neg_d;
    rem_q <= rem_d;
  end

  // floor modulo of a negative value: mirror a non-zero remainder
  logic [SIZE_W-1:0] mirror;
  assign mirror = div_q - SIZE_W'(rem_q);
  assign rem_o  = (neg_q && (rem_q != '0)) ? mirror[POS_W-1:0] : rem_q;
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("remainder unit restarted while busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (SIZE_W'(rem_o) < div_q)) else $error("remainder not below divisor");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q)) else $error("done without a finished run");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q < CNT_W'(DVD_W))) else $error("step counter overran");
`endif

endmodule

`default_nettype wire

// ===== rtl/rpd_datapath.sv =====
// Datapath: config registers, position and run state, operand select and result register.
`default_nettype none

module rpd_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rpd_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic [rpd_pkg::IN_TDATA_W-1:0] in_tdata_i,
  input  wire logic                           in_tuser_i,
  input  wire logic                           out_tready_i,
  output logic                                out_tvalid_o,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]     out_tdata_o,
  output logic                                out_tuser_o,
  input  wire rpd_pkg::rpd_cmd_t              cmd_i,
  output rpd_pkg::rpd_status_t                status_o
);
  import rpd_pkg::*;

  logic [CFG_W-1:0]  gw_cfg_q, gw_cfg_d, gh_cfg_q, gh_cfg_d;
  logic [CFG_W-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [RUN_W-1:0]  run_q, run_d;
  logic              done_q, done_d;
  tok_e              tok_q, tok_d;
  mop_e              mop_q, mop_d;
  logic [RUN_W-1:0]  runw_q, runw_d;
  logic [POS_W-1:0]  spx_q, spx_d, spy_q, spy_d;
  logic              ovld_q, ovld_d;
  logic [OUT_TDATA_W-1:0] odata_q, odata_d;
  logic              ouser_q, ouser_d;

  logic [CHAR_W-1:0] ch;
  logic              start;
  logic [RUN_W-1:0]  run_base;
  logic [PROD_W-1:0] prod;
  tok_e              tok;
  logic [SIZE_W-1:0] gw, gh;
  logic [SIZE_W-1:0] span_len;
  logic [OFS_W-1:0]  ofs, mag;
  logic              mod_done;
  logic [POS_W-1:0]  mod_rem;
  logic [DVD_W-1:0]  mod_dvd;
  logic [SIZE_W-1:0] mod_div;
  logic              mod_neg;

  assign ch    = in_tdata_i[CHAR_W-1:0];
  assign start = in_tuser_i;
  assign gw    = eff_size(gw_cfg_q);
  assign gh    = eff_size(gh_cfg_q);

  always_comb begin
    run_base = start ? '0 : run_q;
    prod = PROD_W'({run_base, 3'b000}) + PROD_W'({run_base, 1'b0})
         + PROD_W'(ch - CH_ZERO);
    if (done_q && !start) begin
      tok = TOK_SKIP;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      tok = TOK_DIGIT;
    end else if (ch == CH_NUL || ch == CH_BANG) begin
      tok = TOK_FIN;
    end else if (ch == CH_B) begin
      tok = TOK_COL;
    end else if (ch == CH_O) begin
      tok = TOK_SPAN;
    end else if (ch == CH_DOLLAR) begin
      tok = TOK_ROW;
    end else begin
      tok = TOK_OTHER;
    end
  end

  // remainder operand: signed anchor offsets go in as magnitude plus sign
  always_comb begin
    ofs     = '0;
    mod_dvd = '0;
    mod_div = gw;
    mod_neg = 1'b0;
    unique case (cmd_i.mop)
      MOP_X: begin
        ofs     = OFS_W'(signed'(ax_q)) + OFS_W'(col_q);
        mod_div = gw;
      end
      MOP_Y: begin
        ofs     = OFS_W'(signed'(ay_q)) + OFS_W'(row_q);
        mod_div = gh;
      end
      MOP_COL: begin
        mod_dvd = DVD_W'(col_q) + DVD_W'(runw_q);
        mod_div = gw;
      end
      MOP_ROW: begin
        mod_dvd = DVD_W'(row_q) + DVD_W'(runw_q);
        mod_div = gh;
      end
      default: ;
    endcase
    mag = ofs[OFS_W-1] ? (~ofs + 1'b1) : ofs;
    if (cmd_i.mop == MOP_X || cmd_i.mop == MOP_Y) begin
      mod_neg = ofs[OFS_W-1];
      mod_dvd = DVD_W'(mag);
    end
  end

  rpd_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mod_start),
    .dvd_i   (mod_dvd),
    .div_i   (mod_div),
    .neg_i   (mod_neg),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign span_len = (SIZE_W'(runw_q) > gw || runw_q > RUN_W'(gw)) ? gw
                                                                  : SIZE_W'(runw_q);

  always_comb begin
    gw_cfg_d = gw_cfg_q;
    gh_cfg_d = gh_cfg_q;
    ax_d     = ax_q;
    ay_d     = ay_q;
    col_d    = col_q;
    row_d    = row_q;
    run_d    = run_q;
    done_d   = done_q;
    tok_d    = tok_q;
    mop_d    = mop_q;
    runw_d   = runw_q;
    spx_d    = spx_q;
    spy_d    = spy_q;
    ovld_d   = ovld_q;
    odata_d  = odata_q;
    ouser_d  = ouser_q;

    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GRID_W:   gw_cfg_d = cfg_data_i;
        CFG_GRID_H:   gh_cfg_d = cfg_data_i;
        CFG_ANCHOR_X: ax_d     = cfg_data_i;
        CFG_ANCHOR_Y: ay_d     = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.load) begin
      tok_d = tok;
      if (start) begin
        col_d  = '0;
        row_d  = '0;
        run_d  = '0;
        done_d = 1'b0;
      end
      case (tok)
        TOK_SKIP: ;
        TOK_DIGIT: run_d = (prod > PROD_W'(RUN_MAX)) ? RUN_MAX : prod[RUN_W-1:0];
        default: begin
          run_d  = '0;
          runw_d = (run_base == '0) ? RUN_W'(1) : run_base;
          if (tok == TOK_FIN) begin
            done_d = 1'b1;
          end
        end
      endcase
    end

    if (cmd_i.mod_start) begin
      mop_d = cmd_i.mop;
    end

    if (mod_done) begin
      unique case (mop_q)
        MOP_X:   spx_d = mod_rem;
        MOP_Y:   spy_d = mod_rem;
        MOP_COL: col_d = mod_rem;
        MOP_ROW: begin
          row_d = mod_rem;
          col_d = '0;
        end
        default: ;
      endcase
    end

    if (ovld_q && out_tready_i) begin
      ovld_d = 1'b0;
    end
    if (cmd_i.emit) begin
      ovld_d = 1'b1;
      if (tok_q == TOK_FIN) begin
        odata_d = '0;
        ouser_d = 1'b1;
      end else begin
        odata_d = OUT_TDATA_W'({span_len, spy_q, spx_q});
        ouser_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_cfg_q <= GRID_RESET;
      gh_cfg_q <= GRID_RESET;
      ax_q     <= '0;
      ay_q     <= '0;
      col_q    <= '0;
      row_q    <= '0;
      run_q    <= '0;
      done_q   <= 1'b0;
      tok_q    <= TOK_SKIP;
      mop_q    <= MOP_X;
      ovld_q   <= 1'b0;
    end else begin
      gw_cfg_q <= gw_cfg_d;
      gh_cfg_q <= gh_cfg_d;
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      col_q    <= col_d;
      row_q    <= row_d;
      run_q    <= run_d;
      done_q   <= done_d;
      tok_q    <= tok_d;
      mop_q    <= mop_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    runw_q  <= runw_d;
    spx_q   <= spx_d;
    spy_q   <= spy_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

  assign status_o.tok      = tok;
  assign status_o.tok_q    = tok_q;
  assign status_o.mod_done = mod_done;
  assign status_o.out_free = !ovld_q || out_tready_i;

  assign out_tvalid_o = ovld_q;
  assign out_tdata_o  = odata_q;
  assign out_tuser_o  = ouser_q;

endmodule

`default_nettype wire

// ===== rtl/rpd_ctrl.sv =====
// Controller: sequences token decode, remainder operations and result hand-off.
`default_nettype none

module rpd_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_tvalid_i,
  output logic                      in_tready_o,
  input  wire rpd_pkg::rpd_status_t status_i,
  output rpd_pkg::rpd_cmd_t         cmd_o
);
  import rpd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_tready_o     = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.mod_start = 1'b0;
    cmd_o.mop       = MOP_X;
    cmd_o.emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          case (status_i.tok)
            TOK_FIN:  state_d = ST_EMIT;
            TOK_COL:  state_d = ST_C_GO;
            TOK_SPAN: state_d = ST_X_GO;
            TOK_ROW:  state_d = ST_R_GO;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_X_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mop       = MOP_X;
        state_d         = ST_X_WAIT;
      end
      ST_X_WAIT: if (status_i.mod_done) state_d = ST_Y_GO;
      ST_Y_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mop       = MOP_Y;
        state_d         = ST_Y_WAIT;
      end
      ST_Y_WAIT: if (status_i.mod_done) state_d = ST_C_GO;
      ST_C_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mop       = MOP_COL;
        state_d         = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        if (status_i.mod_done) begin
          state_d = (status_i.tok_q == TOK_SPAN) ? ST_EMIT : ST_IDLE;
        end
      end
      ST_R_GO: begin
        cmd_o.mod_start = 1'b1;
        cmd_o.mop       = MOP_ROW;
        state_d         = ST_R_WAIT;
      end
      ST_R_WAIT: if (status_i.mod_done) state_d = ST_IDLE;
      ST_EMIT: begin
        // hold until the result register has room
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rle_pattern_decoder_core.sv =====
// Top level of the run-length pattern decoder: controller plus datapath.
// Usage:
//  s_axis carries one pattern character per request: tdata[7:0] is the byte,
//  tuser marks the first byte of a pattern (clears position, run and finish).
//  m_axis returns spans: tdata holds span_x, span_y, span_len from bit 0 up,
//  tuser high for the finished marker (all tdata zero then).
//  cfg writes grid width/height and signed anchors by index 0..3; only
//  write while the core is idle. cfg_ready_o is always high.
// Sequencing: digits, unknown and ignored bytes are handled in the idle state. 'b' and '$'
//  run the remainder unit once, 'o' three times (anchor x, anchor y, column), each run
//  working one dividend bit per cycle (17 steps, once per wrapped coordinate).
//  Terminators go to the emit state and wait there for room in the result register.
// The result register decouples the sides: a new byte is accepted while a
//  span waits, but a further span waits in the controller until the
//  receiver takes the pending one.
// Reset clears position, run, finish flag and sets a 64 x 64 grid at origin.
`default_nettype none

module rle_pattern_decoder_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rpd_pkg::IN_TDATA_W-1:0] s_axis_tdata,  // char_code
  input  wire logic                           s_axis_tuser,  // start_flag
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // span_x, span_y, span_len
  output logic                                m_axis_tuser,  // finished
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rpd_pkg::CFG_W-1:0]      cfg_data_i
);
  import rpd_pkg::*;

  rpd_cmd_t    cmd;
  rpd_status_t status;

  assign cfg_ready_o = 1'b1;

  rpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rpd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

`default_nettype wire

// ===== tb/rle_pattern_decoder_core_test.sv =====
// Self-checking test of the run-length pattern decoder core: text stimulus and span check.
`timescale 1ns / 1ps

module rle_pattern_decoder_core_test;
  import rpd_pkg::*;

  localparam int          CLK_HALF     = 2;
  localparam int          RESET_CYCLES = 6;
  localparam int          SETTLE_CYCLES = 100;
  localparam int          PHASES       = 7;
  localparam int          PHASE_ITEMS  = 245;
  localparam int          MAX_SHOWN    = 40;
  localparam longint      CYCLE_LIMIT  = 1_000_000;
  localparam logic [7:0]  CH_JUNK      = 8'h78;

  // expected spans and the decoder state that produces them
  class span_scoreboard;
    typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SIZE_W-1:0] len;
      logic              fin;
    } span_t;

    span_t            due_q[$];
    logic [CFG_W-1:0] width_reg  = CFG_W'(64);
    logic [CFG_W-1:0] height_reg = CFG_W'(64);
    logic [CFG_W-1:0] anchor_x_reg = '0;
    logic [CFG_W-1:0] anchor_y_reg = '0;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      run_count;
    bit               finished;
    int               errors;
    int               live_items;

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_GRID_W:   width_reg    = v;
        CFG_GRID_H:   height_reg   = v;
        CFG_ANCHOR_X: anchor_x_reg = v;
        CFG_ANCHOR_Y: anchor_y_reg = v;
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [CFG_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAX_GRID) return MAX_GRID;
      return int'(v);
    endfunction

    function int unsigned anchor_offset(logic [CFG_W-1:0] raw, int unsigned size);
      int a;
      int r;
      a = int'($signed(raw));
      r = a % int'(size);
      if (r < 0) r += int'(size);
      return r;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // returns 1 when the byte was acted on, 0 when swallowed after a terminator
    function bit note_char(logic [7:0] c, bit st);
      int unsigned gw;
      int unsigned gh;
      int unsigned n;
      int unsigned span_run;
      span_t       s;
      gw = clamp_size(width_reg);
      gh = clamp_size(height_reg);
      if (st) begin
        col_pos = 0;
        row_pos = 0;
        run_count = 0;
        finished = 0;
      end
      if (finished) return 0;
      live_items++;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        n = run_count * 10 + int'(c - CH_ZERO);
        run_count = (n > RUN_MAX) ? RUN_MAX : n;
        return 1;
      end
      span_run = (run_count == 0) ? 1 : run_count;
      run_count = 0;
      if (c == CH_NUL || c == CH_BANG) begin
        finished = 1;
        s = '{x: '0, y: '0, len: '0, fin: 1'b1};
        due_q.push_back(s);
      end else if (c == CH_B) begin
        col_pos = (col_pos % gw + span_run % gw) % gw;
      end else if (c == CH_O) begin
        s.x   = POS_W'((anchor_offset(anchor_x_reg, gw) + col_pos % gw) % gw);
        s.y   = POS_W'((anchor_offset(anchor_y_reg, gh) + row_pos % gh) % gh);
        s.len = SIZE_W'((span_run > gw) ? gw : span_run);
        s.fin = 1'b0;
        due_q.push_back(s);
        col_pos = (col_pos % gw + span_run % gw) % gw;
      end else if (c == CH_DOLLAR) begin
        row_pos = (row_pos % gh + span_run % gh) % gh;
        col_pos = 0;
      end
      return 1;
    endfunction

    task report(string msg);
      if (errors < MAX_SHOWN) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_span(logic [OUT_TDATA_W-1:0] d, logic fin);
      span_t s;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected span data %h fin %0b", d, fin));
        return;
      end
      s = due_q.pop_front();
      if (d[POS_W-1:0] !== s.x)
        report($sformatf("span_x %0d, wanted %0d", d[POS_W-1:0], s.x));
      if (d[2*POS_W-1:POS_W] !== s.y)
        report($sformatf("span_y %0d, wanted %0d", d[2*POS_W-1:POS_W], s.y));
      if (d[2*POS_W+SIZE_W-1:2*POS_W] !== s.len)
        report($sformatf("span_len %0d, wanted %0d", d[2*POS_W+SIZE_W-1:2*POS_W], s.len));
      if (d[OUT_TDATA_W-1:2*POS_W+SIZE_W] !== '0)
        report($sformatf("tdata pad bits not zero: %h", d));
      if (fin !== s.fin)
        report($sformatf("finished %0b, wanted %0b", fin, s.fin));
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = CFG_GRID_W;
  logic [CFG_W-1:0]       cfg_data_i = '0;

  span_scoreboard span_sb = new();
  bit             idle_enabled = 1'b1;
  longint         cycle_count = 0;

  rle_pattern_decoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // span receiver: sample with the pre-edge ready, then pick the next one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      span_sb.check_span(m_axis_tdata, m_axis_tuser);
    end
    m_axis_tready <= idle_enabled ? ($urandom_range(99) >= 18) : 1'b1;
  end

  // valid is only lowered for a gap, so back-to-back requests keep it high
  task automatic push_char(logic [7:0] c, bit st);
    if (idle_enabled && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    void'(span_sb.note_char(c, st));
  endtask

  // count < 0 sends the op with no run digits
  task automatic push_run(int count, logic [7:0] op, bit st);
    string digits;
    digits = (count >= 0) ? $sformatf("%0d", count) : "";
    for (int i = 0; i < digits.len(); i++) begin
      push_char(digits[i], st && i == 0);
    end
    push_char(op, st && digits.len() == 0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (span_sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    span_sb.set_reg(idx, v);
  endtask

  task automatic program_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h,
                              logic [CFG_W-1:0] ax, logic [CFG_W-1:0] ay);
    write_reg(CFG_GRID_W, w);
    write_reg(CFG_GRID_H, h);
    write_reg(CFG_ANCHOR_X, ax);
    write_reg(CFG_ANCHOR_Y, ay);
    cfg_valid_i <= 1'b0;
  endtask

  // one pattern string with random tokens, or a burst of raw noise
  task automatic send_pattern();
    int  r;
    int  count;
    bit  first;
    logic [7:0] op;
    first = 1'b1;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      return;
    end
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(99);
      if (r < 40)      count = -1;
      else if (r < 75) count = $urandom_range(1, 99);
      else if (r < 88) count = $urandom_range(100, 9999);
      else if (r < 94) count = 0;
      else             count = $urandom_range(65530, 999999);
      r = $urandom_range(99);
      if (r < 45)      op = CH_O;
      else if (r < 75) op = CH_B;
      else if (r < 93) op = CH_DOLLAR;
      else             op = 8'($urandom_range(0, 255));
      push_run(count, op, first);
      first = 1'b0;
    end
    r = $urandom_range(99);
    if (r < 50)      push_char(CH_BANG, 1'b0);
    else if (r < 85) push_char(CH_NUL, 1'b0);
    repeat ($urandom_range(0, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  initial begin
    int target;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid 64 x 64 at the origin
    push_run(-1, CH_O, 1'b1);
    push_run(3, CH_O, 1'b0);
    push_run(0, CH_O, 1'b0);
    push_run(2, CH_B, 1'b0);
    push_run(-1, CH_DOLLAR, 1'b0);
    push_run(100, CH_O, 1'b0);        // longer than the row
    push_run(70000, CH_O, 1'b0);      // run saturates
    push_run(5, CH_JUNK, 1'b0);       // unknown byte drops the run
    push_run(-1, CH_O, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(CH_BANG, 1'b0);
    push_char(CH_O, 1'b0);            // swallowed after the terminator
    push_char(CH_NINE, 1'b0);
    push_char(CH_NUL, 1'b1);          // start straight into a terminator
    push_run(-1, CH_O, 1'b1);
    push_char(CH_BANG, 1'b0);
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      // leave a pattern half done so the new grid applies to stale positions
      push_run(7, CH_B, 1'b1);
      push_run(5, CH_DOLLAR, 1'b0);
      settle();
      case (phase)
        0: program_grid(11'd1, 11'd1, 11'h400, 11'h3FF);
        1: program_grid(11'd1024, 11'd1024, 11'h3FF, 11'h400);
        2: program_grid(11'd0, 11'd2047, 11'h7FF, 11'd5);
        3: program_grid(11'd2047, 11'd0, 11'($urandom_range(0, 2047)),
                        11'($urandom_range(0, 2047)));
        6: program_grid(11'd64, 11'd64, 11'd0, 11'd0);
        default: program_grid(11'($urandom_range(2, 40)), 11'($urandom_range(2, 40)),
                              11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      endcase
      idle_enabled = (phase != 4);
      push_run(2, CH_O, 1'b0);
      push_run(3, CH_B, 1'b0);
      push_run(-1, CH_O, 1'b0);
      push_char(CH_BANG, 1'b0);
      target = span_sb.live_items + PHASE_ITEMS;
      while (span_sb.live_items < target) send_pattern();
      settle();
    end

    if (span_sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
